// File: hdl/pidr_pkg.sv
package pidr_pkg;

    localparam int OPCODE_W = 2;
    localparam int ID_W     = 64;

    // operation codes; the unused code acts as check only
    localparam logic [OPCODE_W-1:0] OP_CHECK        = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT       = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CHECK_INSERT = 2'd2;

    // one 128-bit packet identifier as two halves
    typedef struct packed {
        logic [ID_W-1:0] hi;
        logic [ID_W-1:0] lo;
    } pidr_id_t;

endpackage

// File: hdl/pidr_if.sv
interface pidr_req_if;
    import pidr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     id_high;
    logic [ID_W-1:0]     id_low;

    modport source (output valid, output opcode, output id_high, output id_low, input ready);
    modport sink   (input valid, input opcode, input id_high, input id_low, output ready);
endinterface

interface pidr_rsp_if;
    logic valid;
    logic ready;
    logic duplicate;

    modport source (output valid, output duplicate, input ready);
    modport sink   (input valid, input duplicate, output ready);
endinterface

// File: hdl/packet_id_dedup_ring_top.sv
// Duplicate filter for 128-bit packet identifiers kept in a ring of ENTRIES
// slots. A request carries an opcode (check, insert, check then insert if new)
// and the identifier; one response with the duplicate flag comes back per
// request. Lookups walk the filled slots one per cycle through a single
// memory read port and one shared 128-bit comparator, stopping early on a
// match; a miss on check then insert goes on to the write state, a plain
// insert goes straight to the write state and a check on an empty ring
// straight to the response state. The block returns to idle after each
// request before the next can be taken, so it takes one request at a time;
// a finished response waits in an output register while the next request
// is accepted. Slots fill in ring order from zero, so a fill count marks
// which are valid and no clearing pass is needed after reset.
module packet_id_dedup_ring_top #(
    parameter int ENTRIES = 64
) (
    input logic       clk,
    input logic       rst_n,
    pidr_req_if.sink  req,
    pidr_rsp_if.source rsp
);
    import pidr_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [OPCODE_W-1:0] op_reg;
    pidr_id_t            key_reg;
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic                dup_reg, dup_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_dup_reg, out_dup_next;

    logic     accept;
    logic     rd_en;
    logic     wr_en;
    logic     match;
    pidr_id_t rd_id;

    assign accept = req.valid && req.ready;
    assign rd_en  = (state_reg == ST_SCAN) && (scan_idx_reg < fill_reg);
    assign wr_en  = (state_reg == ST_WRITE);

    // identifier store
    pidr_ram #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (head_reg),
        .wr_id   (key_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_id   (rd_id)
    );

    // shared comparator
    pidr_cmp u_cmp (
        .entry_id (rd_id),
        .key_id   (key_reg),
        .match    (match)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        dup_next       = dup_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_dup_next   = out_dup_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dup_next      = 1'b0;
                    scan_idx_next = '0;
                    if (req.opcode == OP_INSERT)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = (req.opcode == OP_CHECK_INSERT) ? ST_WRITE : ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next = rd_en;
                if (rd_en)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (pend_reg && match)
                begin
                    dup_next   = 1'b1;
                    state_next = ST_RESP;
                end
                else if (!rd_en && !pend_reg)
                begin
                    state_next = (op_reg == OP_CHECK_INSERT) ? ST_WRITE : ST_RESP;
                end
            end
            ST_WRITE:
            begin
                head_next  = (head_reg == LAST) ? '0 : head_reg + AW'(1);
                if (fill_reg != FULL)
                begin
                    fill_next = fill_reg + CW'(1);
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dup_next   = dup_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_dup_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            dup_reg       <= dup_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            out_dup_reg   <= out_dup_next;
        end
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.opcode;
            key_reg.hi <= req.id_high;
            key_reg.lo <= req.id_low;
        end
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.duplicate = out_dup_reg;

`ifndef SYNTHESIS
    // fill count never passes the ring size
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FULL)
        else $error("fill count beyond ring size");

    // until the ring wraps, the head sits right after the filled slots
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FULL) |-> (head_reg == fill_reg[AW-1:0]))
        else $error("write head out of step with fill count");

    // a write never follows a match
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !dup_reg)
        else $error("insert after a duplicate was found");

    // the scan index stays within the filled slots
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= fill_reg))
        else $error("scan ran past the filled slots");
`endif

endmodule

// File: hdl/pidr_ram.sv
module pidr_ram #(
    parameter int ENTRIES = 64,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  pidr_pkg::pidr_id_t wr_id,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output pidr_pkg::pidr_id_t rd_id
);
    import pidr_pkg::*;

    pidr_id_t mem [ENTRIES];
    pidr_id_t rd_id_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_id;
        end
    end

    // single registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id_reg <= mem[rd_addr];
        end
    end

    assign rd_id = rd_id_reg;

endmodule

// File: hdl/pidr_cmp.sv
module pidr_cmp (
    input  pidr_pkg::pidr_id_t entry_id,
    input  pidr_pkg::pidr_id_t key_id,
    output logic               match
);
    import pidr_pkg::*;

    // both halves must agree
    assign match = (entry_id.hi == key_id.hi) && (entry_id.lo == key_id.lo);

endmodule

// File: tb/sv/tb_packet_id_dedup_ring_top.sv
`timescale 1ns / 1ps

module tb_packet_id_dedup_ring_top;
    import pidr_pkg::*;

    localparam int RING_SLOTS = 64;

    // the fourth opcode value is unused and behaves as check only
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    localparam pidr_id_t ID_ZERO  = '0;
    localparam pidr_id_t ID_ONES  = '1;
    localparam pidr_id_t ID_ALPHA = {64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210};
    localparam pidr_id_t ID_BETA  = {64'h8000_0000_0000_0001, 64'h5555_aaaa_5555_aaaa};

    typedef struct {
        logic [OPCODE_W-1:0] op;
        pidr_id_t            id;
        logic                dup;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    pidr_req_if req_bus ();
    pidr_rsp_if rsp_bus ();

    packet_id_dedup_ring_top #(
        .ENTRIES(RING_SLOTS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    // shadow copy of the identifier ring
    pidr_id_t ring_id [RING_SLOTS];
    logic     ring_filled [RING_SLOTS] = '{default: 1'b0};
    int       ring_head = 0;

    verdict_t pending_verdicts [$];
    pidr_id_t id_history [$];

    int  error_count = 0;
    int  sent_count = 0;
    int  dup_seen = 0;
    int  op_count [4] = '{default: 0};
    bit  steady_mode = 1'b0;
    int  rsp_hold_request = 0;
    int  rsp_hold_left = 0;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // lookup against filled slots, then ring insert where the opcode calls for it
    function automatic logic predict_verdict(input logic [OPCODE_W-1:0] op,
                                             input pidr_id_t id);
        logic hit;
        int   k;
        hit = 1'b0;
        if (op != OP_INSERT)
        begin
            for (k = 0; k < RING_SLOTS; k++)
            begin
                if (ring_filled[k] && ring_id[k] == id)
                    hit = 1'b1;
            end
        end
        if (op == OP_INSERT || (op == OP_CHECK_INSERT && !hit))
        begin
            ring_id[ring_head]     = id;
            ring_filled[ring_head] = 1'b1;
            ring_head = (ring_head == RING_SLOTS - 1) ? 0 : ring_head + 1;
        end
        return hit;
    endfunction

    function automatic logic [ID_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // offer one request, record its predicted verdict once accepted
    task automatic send_request(input logic [OPCODE_W-1:0] op, input pidr_id_t id);
        verdict_t entry;
        while (!steady_mode && $urandom_range(99) < 15)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.opcode  <= op;
        req_bus.id_high <= id.hi;
        req_bus.id_low  <= id.lo;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        entry.op  = op;
        entry.id  = id;
        entry.dup = predict_verdict(op, id);
        pending_verdicts.push_back(entry);
        sent_count++;
        op_count[op]++;
    endtask

    // drop valid and wait for every outstanding response
    task automatic drain_requests();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // response checker and ready driver
    always @(posedge clk)
    begin
        verdict_t head;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: response with no pending request, expected none, actual dup=%0b",
                         $time, rsp_bus.duplicate);
                error_count++;
            end
            else
            begin
                head = pending_verdicts.pop_front();
                if (rsp_bus.duplicate !== head.dup)
                begin
                    $display("%0t: duplicate mismatch op %0d id %h_%h: expected %0b, actual %0b",
                             $time, head.op, head.id.hi, head.id.lo, head.dup,
                             rsp_bus.duplicate);
                    error_count++;
                end
                if (rsp_bus.duplicate === 1'b1)
                    dup_seen++;
            end
        end
        // long hold-off when asked, otherwise random stalls outside steady mode
        if (rsp_hold_request > 0)
        begin
            rsp_hold_left    = rsp_hold_request;
            rsp_hold_request = 0;
        end
        if (rsp_hold_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
        end
        else if (steady_mode)
            rsp_bus.ready <= 1'b1;
        else
            rsp_bus.ready <= ($urandom_range(99) >= 15);
    end

    // empty ring, extremes, every opcode, half matches, duplicate slots
    task automatic test_directed();
        send_request(OP_CHECK, ID_ZERO);
        send_request(OP_CHECK, ID_ONES);
        send_request(OP_SPARE, ID_ONES);
        send_request(OP_INSERT, ID_ZERO);
        send_request(OP_CHECK, ID_ZERO);
        send_request(OP_CHECK_INSERT, ID_ONES);
        send_request(OP_CHECK, ID_ONES);
        send_request(OP_CHECK_INSERT, ID_ONES);
        send_request(OP_SPARE, ID_ZERO);
        // spare code must not insert
        send_request(OP_SPARE, ID_ALPHA);
        send_request(OP_CHECK, ID_ALPHA);
        // plain insert twice leaves two equal slots
        send_request(OP_INSERT, ID_ALPHA);
        send_request(OP_INSERT, ID_ALPHA);
        send_request(OP_CHECK, ID_ALPHA);
        // only one half equal is a miss
        send_request(OP_CHECK, {ID_ALPHA.hi, ~ID_ALPHA.lo});
        send_request(OP_CHECK, {~ID_ALPHA.hi, ID_ALPHA.lo});
        send_request(OP_CHECK, {ID_ZERO.hi, ID_ONES.lo});
        send_request(OP_CHECK_INSERT, {ID_ONES.hi, ID_ZERO.lo});
        send_request(OP_CHECK, {ID_ONES.hi, ID_ZERO.lo});
        send_request(OP_CHECK_INSERT, ID_BETA);
        send_request(OP_CHECK, ID_BETA);
        send_request(OP_SPARE, ID_BETA);
        drain_requests();
    endtask

    // fill past the ring size so the oldest slots are overwritten
    task automatic test_ring_wrap();
        pidr_id_t fill_ids [$];
        pidr_id_t id;
        int       n;
        for (n = 0; n < RING_SLOTS + 6; n++)
        begin
            id = {rand_word(), rand_word()};
            fill_ids.push_back(id);
            send_request(OP_INSERT, id);
        end
        send_request(OP_CHECK, ID_ZERO);
        send_request(OP_CHECK, fill_ids[0]);
        send_request(OP_CHECK, fill_ids[6]);
        send_request(OP_CHECK, fill_ids[RING_SLOTS + 5]);
        send_request(OP_CHECK_INSERT, fill_ids[0]);
        send_request(OP_CHECK, fill_ids[0]);
        drain_requests();
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        int n;
        rsp_hold_request = 400;
        for (n = 0; n < 20; n++)
        begin
            if (n % 3 == 0)
                send_request(OP_CHECK_INSERT, {rand_word(), rand_word()});
            else if (n % 3 == 1)
                send_request(OP_INSERT, {rand_word(), rand_word()});
            else
                send_request(OP_CHECK, ID_BETA);
        end
        drain_requests();
    endtask

    // random mix biased toward repeated and near-miss identifiers
    task automatic test_random(input int count);
        pidr_id_t            id;
        logic [OPCODE_W-1:0] op;
        int                  n;
        int                  r;
        for (n = 0; n < count; n++)
        begin
            steady_mode = (n >= count / 3) && (n < count / 3 + 100);
            r = $urandom_range(99);
            if (id_history.size() > 0 && r < 50)
                id = id_history[$urandom_range(id_history.size() - 1)];
            else if (id_history.size() > 0 && r < 65)
            begin
                id = id_history[$urandom_range(id_history.size() - 1)];
                if ($urandom_range(1))
                    id.hi = rand_word();
                else
                    id.lo = rand_word();
            end
            else if (r < 70)
            begin
                case ($urandom_range(3))
                    0: id = ID_ZERO;
                    1: id = ID_ONES;
                    2: id = {ID_ZERO.hi, ID_ONES.lo};
                    default: id = {ID_ONES.hi, ID_ZERO.lo};
                endcase
            end
            else
                id = {rand_word(), rand_word()};
            r = $urandom_range(99);
            if (r < 30)
                op = OP_CHECK;
            else if (r < 55)
                op = OP_INSERT;
            else if (r < 95)
                op = OP_CHECK_INSERT;
            else
                op = OP_SPARE;
            id_history.push_back(id);
            if (id_history.size() > 150)
                void'(id_history.pop_front());
            send_request(op, id);
        end
        steady_mode = 1'b0;
        drain_requests();
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.opcode  = OP_CHECK;
        req_bus.id_high = '0;
        req_bus.id_low  = '0;
        rsp_bus.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_ring_wrap();
        test_backpressure();
        test_random(330);

        repeat (80) @(posedge clk);
        $display("covered %0d requests: %0d check, %0d insert, %0d check-insert, %0d spare code",
                 sent_count, op_count[OP_CHECK], op_count[OP_INSERT],
                 op_count[OP_CHECK_INSERT], op_count[OP_SPARE]);
        $display("%0d duplicates reported, ring wrapped with long response hold-off", dup_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("%0t: timeout with %0d responses outstanding", $time, pending_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
